FILE: rtl/core/sensor_percent_map_with_moving_average_defines.svh
// Assertion helpers shared by the RTL.
// Each expands to one labelled concurrent assertion on i_clk, held off in reset.
`ifndef SENSOR_PERCENT_MAP_WITH_MOVING_AVERAGE_DEFINES_SVH
`define SENSOR_PERCENT_MAP_WITH_MOVING_AVERAGE_DEFINES_SVH

// same-cycle implication
`define SPMAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/spmap_pkg.sv
`timescale 1ns / 1ps

package spmap_pkg;

    // register indexes of the write channel
    localparam logic [1:0] CFG_AIR    = 2'd0;
    localparam logic [1:0] CFG_WATER  = 2'd1;
    localparam logic [1:0] CFG_PERIOD = 2'd2;

    // ring of recent percentages
    localparam int WINDOW_DEPTH = 5;
    localparam int RING_AW      = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // percentage scale
    localparam int PCT_W              = 7;
    localparam logic [PCT_W-1:0] FULL_SCALE = PCT_W'(100);

    // running sum of the ring, at most FULL_SCALE * WINDOW_DEPTH
    localparam int SUM_W = $clog2(100 * WINDOW_DEPTH + 1);

    // window mean by reciprocal multiply: exact floor for any SUM_W-bit sum
    localparam int AVG_SH    = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int AVG_RECIP = (1 << AVG_SH) / WINDOW_DEPTH + 1;
    localparam int AVG_PW    = SUM_W + AVG_SH;

    // shared divider widths: dividend holds 1023 * 100
    localparam int ADC_W = 10;
    localparam int DVD_W = 17;
    localparam int DVS_W = ADC_W;
    localparam int DCNT_W = $clog2(DVD_W + 1);

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

FILE: rtl/core/spmap_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module spmap_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spmap_pkg::t_div_req i_req,
    output spmap_pkg::t_div_rsp o_rsp
);
    import spmap_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVD_W-1:0]  r_quo;

    logic [DVS_W:0]    trial;
    logic              fits;

    assign trial = {r_rem, r_quo[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift in as dividend bits shift out
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], fits};
            r_rem <= fits ? DVS_W'(trial - {1'b0, r_dvs}) : DVS_W'(trial);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

FILE: rtl/core/sensor_percent_map_with_moving_average.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-----------------------------------------
// in       | sink      | i_in_valid / o_in_ready    | i_adc_reading
// out      | source    | o_out_valid / i_out_ready  | o_moisture_percent, o_peak_percent,
//          |           |                            | o_window_average, o_new_peak
// cfg      | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A tick short of the sample point gives no result. A sampled tick closes the input
// while it passes map, the shared 17-bit divider (shifts, then a done strobe), update
// and output load; the divider is skipped if the percentage needs no divide.
// Reset (synchronous, active low) clears the counter, peak, ring and sum at once.
// Output is a holding register: a new request is taken while a result waits, and
// the sequencer stalls only at the final load until that result is taken.
module sensor_percent_map_with_moving_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick requests
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [9:0]  i_adc_reading,
    // results
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_moisture_percent,
    output logic [6:0]  o_peak_percent,
    output logic [6:0]  o_window_average,
    output logic        o_new_peak,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import spmap_pkg::*;

    `include "sensor_percent_map_with_moving_average_defines.svh"

    localparam int ELAPSED_W = 17;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,  // waiting for a tick
        S_MAP  = 5'b00010,  // magnitudes, sign check, start percentage divide
        S_PDIV = 5'b00100,  // percentage divide running
        S_UPD  = 5'b01000,  // peak, ring, sum
        S_HOLD = 5'b10000   // mean and output load, wait for output register to free up
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [ADC_W-1:0]     r_air;
    logic [ADC_W-1:0]     r_water;
    logic [15:0]          r_period;

    // block state
    logic [ELAPSED_W-1:0] r_elapsed;
    logic [PCT_W-1:0]     r_peak;
    logic [PCT_W-1:0]     r_ring [WINDOW_DEPTH];
    logic [RING_AW-1:0]   r_pos;
    logic [SUM_W-1:0]     r_sum;

    // per-sample working registers
    logic [ADC_W-1:0]     r_x;
    logic [PCT_W-1:0]     r_pct;
    logic                 r_raised;

    // output holding register
    logic                 r_out_valid;
    logic [PCT_W-1:0]     r_out_pct;
    logic [PCT_W-1:0]     r_out_peak;
    logic [PCT_W-1:0]     r_out_avg;
    logic                 r_out_raised;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    logic                 in_req;
    logic                 out_free;
    logic [ELAPSED_W-1:0] n_elapsed;
    logic                 take_sample;
    logic                 nneg, dneg;
    logic [ADC_W-1:0]     nmag, dmag;
    logic                 map_zero;
    logic [DVD_W-1:0]     scaled;
    logic [PCT_W-1:0]     q_clamped;
    logic                 raise_now;
    logic [SUM_W-1:0]     n_sum;
    logic [AVG_PW-1:0]    avg_prod;
    logic [PCT_W-1:0]     mean;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_req      = i_in_valid & o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // tick counter: increment (saturating) then compare
    assign n_elapsed   = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
    assign take_sample = (n_elapsed > {1'b0, r_period});

    // signed mapping split into sign and magnitude
    assign nneg     = (r_x < r_air);
    assign nmag     = nneg ? (r_air - r_x) : (r_x - r_air);
    assign dneg     = (r_water < r_air);
    assign dmag     = dneg ? (r_air - r_water) : (r_water - r_air);
    assign map_zero = (r_air == r_water) || (nmag == '0) || (nneg != dneg);
    assign scaled   = DVD_W'(nmag) * DVD_W'(FULL_SCALE);

    assign q_clamped = (div_rsp.quotient > DVD_W'(FULL_SCALE)) ? FULL_SCALE
                                                                : div_rsp.quotient[PCT_W-1:0];

    assign raise_now = (r_pct > r_peak);
    // running sum swaps the slot being overwritten
    assign n_sum     = r_sum - SUM_W'(r_ring[r_pos]) + SUM_W'(r_pct);

    // window mean from the registered sum: multiply by the reciprocal, keep the top bits
    assign avg_prod  = AVG_PW'(r_sum) * AVG_PW'(AVG_RECIP);
    assign mean      = avg_prod[AVG_SH +: PCT_W];

    // shared divider works out the percentage
    always_comb begin
        div_req.start    = (r_state == S_MAP) && !map_zero;
        div_req.dividend = scaled;
        div_req.divisor  = dmag;
    end

    spmap_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_req && take_sample) n_state = S_MAP;
            end
            S_MAP: begin
                n_state = map_zero ? S_UPD : S_PDIV;
            end
            S_PDIV: begin
                if (div_rsp.done) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_air       <= ADC_W'(870);
            r_water     <= ADC_W'(600);
            r_period    <= 16'd1000;
            r_elapsed   <= '0;
            r_peak      <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                priority if (i_cfg_index == CFG_AIR) begin
                    r_air <= i_cfg_data[ADC_W-1:0];
                end else if (i_cfg_index == CFG_WATER) begin
                    r_water <= i_cfg_data[ADC_W-1:0];
                end else if (i_cfg_index == CFG_PERIOD) begin
                    r_period <= i_cfg_data;
                end else begin
                    // unknown index: ignored
                end
            end

            if (in_req) begin
                r_elapsed <= take_sample ? '0 : n_elapsed;
            end

            if (r_state == S_UPD) begin
                if (raise_now) r_peak <= r_pct;
                r_ring[r_pos] <= r_pct;
                r_sum         <= n_sum;
                r_pos         <= (r_pos == RING_AW'(WINDOW_DEPTH - 1)) ? '0 : r_pos + 1'b1;
            end

            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_x <= i_adc_reading;
        end
        if (r_state == S_MAP && map_zero) begin
            r_pct <= '0;
        end else if (r_state == S_PDIV && div_rsp.done) begin
            r_pct <= q_clamped;
        end
        if (r_state == S_UPD) begin
            r_raised <= raise_now;
        end
        if (r_state == S_HOLD && out_free) begin
            r_out_pct    <= r_pct;
            r_out_peak   <= r_peak;
            r_out_avg    <= mean;
            r_out_raised <= r_raised;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_moisture_percent = r_out_pct;
    assign o_peak_percent     = r_out_peak;
    assign o_window_average   = r_out_avg;
    assign o_new_peak         = r_out_raised;

    `SPMAP_ASSERT_NEXT(a_sample_blocks, in_req && take_sample, !o_in_ready, "sample not started")
    `SPMAP_ASSERT_NOW(a_peak_covers, o_out_valid, o_peak_percent >= o_moisture_percent, "peak low")
    `SPMAP_ASSERT_NOW(a_pct_range, o_out_valid, o_moisture_percent <= FULL_SCALE, "pct too large")
    `SPMAP_ASSERT_NOW(a_avg_range, o_out_valid, o_window_average <= FULL_SCALE, "mean too large")
    `SPMAP_ASSERT_NOW(a_div_done, div_rsp.done, r_state == S_PDIV, "stray divider done")

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import spmap_pkg::*;

    // register indexes of the write channel, plus one the block does not know
    typedef enum logic [1:0] {
        REG_AIR    = CFG_AIR,
        REG_WATER  = CFG_WATER,
        REG_PERIOD = CFG_PERIOD,
        REG_SPARE  = 2'd3
    } t_reg_index;

    // one result request as the block should present it
    typedef struct {
        logic [PCT_W-1:0] moisture;
        logic [PCT_W-1:0] peak;
        logic [PCT_W-1:0] average;
        logic             raised;
    } t_reading;

    localparam int STALL_LIMIT  = 2000;   // cycles with no request moving at all
    localparam int SETTLE_TICKS = 64;
    localparam int RANDOM_TICKS = 2000;

    // clock and reset
    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    // bench-side drive of the block's inputs
    logic        in_valid    = 1'b0;
    logic [9:0]  adc_reading = '0;
    logic        out_ready   = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic [1:0]  cfg_index   = REG_AIR;
    logic [15:0] cfg_data    = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic [6:0]  o_moisture_percent;
    logic [6:0]  o_peak_percent;
    logic [6:0]  o_window_average;
    logic        o_new_peak;
    logic        o_cfg_ready;

    sensor_percent_map_with_moving_average u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_adc_reading      (adc_reading),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_moisture_percent (o_moisture_percent),
        .o_peak_percent     (o_peak_percent),
        .o_window_average   (o_window_average),
        .o_new_peak         (o_new_peak),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // shadow of the block: calibration, counter, peak and ring (reset values)
    logic [9:0]           cal_air     = 10'd870;
    logic [9:0]           cal_water   = 10'd600;
    logic [15:0]          cal_period  = 16'd1000;
    logic [16:0]          tick_count  = '0;
    logic [PCT_W-1:0]     peak_seen   = '0;
    logic [PCT_W-1:0]     recent_pct [WINDOW_DEPTH];
    logic [RING_AW-1:0]   recent_pos  = '0;

    logic [9:0] tick_q [$];            // tick requests waiting for the driver
    t_reading   expected_readings [$]; // results owed by the block, oldest first

    logic calm = 1'b0;                 // set: neither side idles
    int   ticks_queued   = 0;
    int   ticks_accepted = 0;
    int   results_seen   = 0;
    int   peaks_seen     = 0;
    int   reg_writes     = 0;
    int   mismatches     = 0;
    int   quiet_cycles   = 0;

    initial begin
        foreach (recent_pct[i]) recent_pct[i] = '0;
    end

    // linear map, air point to 0 and water point to 100, truncated and clamped
    function automatic logic [PCT_W-1:0] percent_of(logic [9:0] x);
        logic [9:0]  num_mag;
        logic [9:0]  den_mag;
        logic        num_neg;
        logic        den_neg;
        logic [16:0] quot;
        if (cal_air == cal_water) return '0;
        num_neg = x < cal_air;
        num_mag = num_neg ? cal_air - x : x - cal_air;
        den_neg = cal_water < cal_air;
        den_mag = den_neg ? cal_air - cal_water : cal_water - cal_air;
        // zero or negative ratio clamps to zero
        if (num_mag == '0 || num_neg != den_neg) return '0;
        quot = (17'(num_mag) * 17'd100) / 17'(den_mag);
        return (quot > 17'(FULL_SCALE)) ? FULL_SCALE : quot[PCT_W-1:0];
    endfunction

    // one accepted tick: advance the counter, and on the sample point owe a result
    task automatic predict_tick(input logic [9:0] x);
        t_reading          r;
        logic [SUM_W-1:0]  total;
        if (tick_count != 17'h1FFFF) tick_count = tick_count + 17'd1;
        if (tick_count <= 17'(cal_period)) return;
        tick_count = '0;
        r.moisture = percent_of(x);
        r.raised   = r.moisture > peak_seen;
        if (r.raised) peak_seen = r.moisture;
        recent_pct[recent_pos] = r.moisture;
        recent_pos = (recent_pos == RING_AW'(WINDOW_DEPTH - 1)) ? '0 : recent_pos + 1'b1;
        total = '0;
        foreach (recent_pct[i]) total = total + SUM_W'(recent_pct[i]);
        r.peak    = peak_seen;
        r.average = PCT_W'(total / SUM_W'(WINDOW_DEPTH));
        expected_readings.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] error: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d (result %0d)",
                                      name, got, want, results_seen));
    endtask

    // ---------------------------------------------------------------------
    // Tick driver. A request is held until taken; the next one (or a gap)
    // is loaded only at an edge where the slot frees up, so valid never
    // drops under a pending request.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid) begin
                predict_tick(adc_reading);
                ticks_accepted++;
            end
            if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                adc_reading <= tick_q.pop_front();
                in_valid    <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor: compare each taken result with the oldest one owed,
    // and throttle ready at random (never while calm).
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_reading want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (expected_readings.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d/%0d with none owed",
                                              o_moisture_percent, o_peak_percent,
                                              o_window_average, o_new_peak));
                end else begin
                    want = expected_readings.pop_front();
                    check_field("moisture_percent", o_moisture_percent, want.moisture);
                    check_field("peak_percent", o_peak_percent, want.peak);
                    check_field("window_average", o_window_average, want.average);
                    check_field("new_peak", 7'(o_new_peak), 7'(want.raised));
                    if (want.raised) peaks_seen++;
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // watchdog: any request moving on any channel restarts the count
    always @(posedge i_clk) begin
        if (rst_n && ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                      || (cfg_valid && o_cfg_ready))) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_tick(input logic [9:0] x);
        tick_q.push_back(x);
        ticks_queued++;
    endtask

    // register write; the shadow copy follows at the edge it is taken
    task automatic write_reg(input t_reg_index idx, input logic [15:0] data);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_AIR:    cal_air    = data[9:0];
            REG_WATER:  cal_water  = data[9:0];
            REG_PERIOD: cal_period = data;
            default: ;  // unknown index, dropped by the block
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // wait for every queued tick to be taken and every owed result to arrive,
    // then give a tick that produced nothing time to finish
    task automatic settle();
        while (ticks_accepted != ticks_queued || expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // reading for the random part: mostly between the calibration points
    function automatic logic [9:0] pick_reading();
        logic [9:0] lo;
        logic [9:0] hi;
        lo = (cal_air < cal_water) ? cal_air : cal_water;
        hi = (cal_air < cal_water) ? cal_water : cal_air;
        case ($urandom_range(9))
            0: return 10'd0;
            1: return 10'd1023;
            2: return cal_air;
            3: return cal_water;
            4, 5: return 10'($urandom_range(1023));
            default: return 10'($urandom_range(hi, lo));
        endcase
    endfunction

    initial begin : stimulus
        int phase;
        int count;
        int random_ticks;
        logic [9:0] level;

        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // --- directed ---
        // short period: only every third tick samples; percentages ramp up
        // so the peak is raised a few times before it reaches the top
        write_reg(REG_PERIOD, 16'd2);
        queue_tick(10'd1023); queue_tick(10'd0); queue_tick(10'd843);
        queue_tick(10'd0); queue_tick(10'd1023); queue_tick(10'd816);
        queue_tick(10'd600); queue_tick(10'd600); queue_tick(10'd789);
        settle();

        // unknown index must be dropped; then sample every tick
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_PERIOD, 16'd0);
        queue_tick(10'd870); queue_tick(10'd871); queue_tick(10'd1023);
        queue_tick(10'd735); queue_tick(10'd601); queue_tick(10'd600);
        queue_tick(10'd0);
        settle();

        // equal calibration points give zero whatever the reading
        write_reg(REG_AIR, 16'hFE00);
        write_reg(REG_WATER, 16'h0200);
        queue_tick(10'd0); queue_tick(10'd512); queue_tick(10'd1023);
        settle();

        // inverted calibration, then the widest normal span
        write_reg(REG_AIR, 16'h0000);
        write_reg(REG_WATER, 16'hFFFF);
        queue_tick(10'd0); queue_tick(10'd1023); queue_tick(10'd511);
        settle();
        write_reg(REG_AIR, 16'hFFFF);
        write_reg(REG_WATER, 16'hFC00);
        queue_tick(10'd0); queue_tick(10'd1023);
        settle();

        // longest period: a few ticks, no sample
        write_reg(REG_PERIOD, 16'hFFFF);
        queue_tick(10'd1023); queue_tick(10'd0);
        settle();

        // --- random phases ---
        phase = 0;
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            calm = (phase >= 12 && phase < 18);
            case ($urandom_range(7))
                0: begin
                    write_reg(REG_AIR, {6'($urandom), 10'd0});
                    write_reg(REG_WATER, {6'($urandom), 10'd1023});
                end
                1: begin
                    write_reg(REG_AIR, {6'($urandom), 10'd1023});
                    write_reg(REG_WATER, {6'($urandom), 10'd0});
                end
                2: begin
                    level = 10'($urandom);
                    write_reg(REG_AIR, {6'($urandom), level});
                    write_reg(REG_WATER, {6'($urandom), level});
                end
                default: begin
                    if ($urandom_range(3) != 0) write_reg(REG_AIR, 16'($urandom));
                    if ($urandom_range(3) != 0) write_reg(REG_WATER, 16'($urandom));
                end
            endcase
            if ($urandom_range(7) == 0) write_reg(REG_SPARE, 16'($urandom));
            case ($urandom_range(15))
                0: write_reg(REG_PERIOD, 16'hFFFF);
                1: write_reg(REG_PERIOD, 16'($urandom_range(30, 8)));
                2, 3, 4: write_reg(REG_PERIOD, 16'd0);
                default: write_reg(REG_PERIOD, 16'($urandom_range(3, 1)));
            endcase
            count = (cal_period == 16'hFFFF) ? 12 : $urandom_range(70, 20);
            repeat (count) queue_tick(pick_reading());
            random_ticks += count;
            settle();
            phase++;
        end
        calm = 1'b0;

        if (expected_readings.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_readings.size()));

        $display("Run covered %0d tick requests, %0d results (%0d with a new peak).",
                 ticks_accepted, results_seen, peaks_seen);
        $display("Register writes: %0d over %0d random phases.", reg_writes, phase);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
